@@ sv/wsw_rc_pkg.sv @@
// ----------------------------------------------------------------------------
// wsw_rc_pkg
// Shared codes and widths for the stop-and-wait retry control block.
// ----------------------------------------------------------------------------
package wsw_rc_pkg;

  localparam int KIND_W    = 4;
  localparam int BITS_W    = 20;
  localparam int LIMIT_W   = 8;
  localparam int RETRY_W   = 8;
  localparam int STA_W     = 9;
  localparam int OUTCOME_W = 3;
  localparam int TXC_W     = 10;
  localparam int ATT_W     = 9;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  // event kinds
  localparam logic [KIND_W-1:0] K_NEW_FRAME   = 4'd0;
  localparam logic [KIND_W-1:0] K_TX_START    = 4'd1;
  localparam logic [KIND_W-1:0] K_TX_END_ACT  = 4'd2;
  localparam logic [KIND_W-1:0] K_TX_END_OTH  = 4'd3;
  localparam logic [KIND_W-1:0] K_RX_START    = 4'd4;
  localparam logic [KIND_W-1:0] K_RX_END      = 4'd5;
  localparam logic [KIND_W-1:0] K_RX_ERROR    = 4'd6;
  localparam logic [KIND_W-1:0] K_ACK_RX      = 4'd7;
  localparam logic [KIND_W-1:0] K_DATA_RX     = 4'd8;
  localparam logic [KIND_W-1:0] K_ACK_TIMEOUT = 4'd9;
  localparam logic [KIND_W-1:0] K_CTS_MISSING = 4'd10;

  // outcomes
  localparam logic [OUTCOME_W-1:0] OC_NONE       = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_QUEUED     = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_DROP_EXP   = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_SUCCESS    = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_RETRANSMIT = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_DISCARD    = 3'd5;
  localparam logic [OUTCOME_W-1:0] OC_ACK_SEND   = 3'd6;

  // ack phases
  localparam logic [PHASE_W-1:0] PH_NONE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RECV = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DONE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SACK = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RTS_THRESH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIANCHI     = 2'd3;

  // reset values
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 8'd7;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 8'd4;
  localparam logic [BITS_W-1:0]  RTS_THRESH_RST  = 20'd4000;

  localparam logic [RETRY_W-1:0] RETRY_MAX = 8'd255;
  localparam logic [STA_W-1:0]   STA_MAX   = 9'd511;

endpackage

@@ sv/wlan_stop_and_wait_retry_control.sv @@
// ----------------------------------------------------------------------------
// wlan_stop_and_wait_retry_control
// Sender side of a stop-and-wait ARQ with DCF short/long retry counters; also tracks acks owed for received data.
// ----------------------------------------------------------------------------
// throughput: one event per cycle while out_tready does not stall the output; one input stage register and one output
//   register, the state update is combinational between them
// reset: synchronous, active low; clears all counters and the ack phase,
//   loads the retry limits, rts threshold and mode with their defaults
module wlan_stop_and_wait_retry_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] frame_bits, [20] expired, zeros above
  input  logic [3:0]  in_tuser,   // [3:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] tx_count, [18:10] attempts,
                                  // [21:19] ack_phase, [22] busy_res, zero above
  output logic [2:0]  out_tuser   // [2:0] outcome
);

  // configuration
  logic [wsw_rc_pkg::LIMIT_W-1:0] short_lim_r, long_lim_r;
  logic [wsw_rc_pkg::BITS_W-1:0]  thr_r;
  logic                           bianchi_r;

  // input stage
  logic                            stg_v_r;
  logic [wsw_rc_pkg::KIND_W-1:0]   stg_kind_r;
  logic [wsw_rc_pkg::BITS_W-1:0]   stg_bits_r;
  logic                            stg_exp_r;

  // protocol state
  logic [wsw_rc_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                           active_r, active_nxt;
  logic                           timer_r, timer_nxt;
  logic [wsw_rc_pkg::BITS_W-1:0]  act_bits_r, act_bits_nxt;
  logic [wsw_rc_pkg::RETRY_W-1:0] sr_r, sr_nxt, lr_r, lr_nxt;
  logic [wsw_rc_pkg::STA_W-1:0]   ss_r, ss_nxt, sl_r, sl_nxt;

  // output register
  logic                             out_v_r;
  logic [wsw_rc_pkg::OUTCOME_W-1:0] oc_r, oc_nxt;
  logic [wsw_rc_pkg::TXC_W-1:0]     txc_r, txc_nxt;
  logic [wsw_rc_pkg::ATT_W-1:0]     att_r, att_nxt;
  logic [wsw_rc_pkg::PHASE_W-1:0]   ph_out_r;
  logic                             busy_r, busy_nxt;

  logic adv, fire, in_acc;
  logic is_long, to_fail, do_fail;
  logic [wsw_rc_pkg::STA_W-1:0] s_part, l_part;
  logic [wsw_rc_pkg::TXC_W-1:0] std_cnt, per_frame_cnt;

  assign adv       = !out_v_r || out_tready;
  assign fire      = stg_v_r && adv;
  assign in_tready = !stg_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign is_long = act_bits_r > thr_r;

  always_comb begin
    phase_nxt    = phase_r;
    active_nxt   = active_r;
    timer_nxt    = timer_r;
    act_bits_nxt = act_bits_r;
    sr_nxt       = sr_r;
    lr_nxt       = lr_r;
    ss_nxt       = ss_r;
    sl_nxt       = sl_r;
    oc_nxt       = wsw_rc_pkg::OC_NONE;
    txc_nxt      = wsw_rc_pkg::TXC_W'(1);
    att_nxt      = wsw_rc_pkg::ATT_W'(1);
    to_fail      = 1'b0;
    do_fail      = 1'b0;
    s_part       = '0;
    l_part       = '0;
    std_cnt      = '0;
    per_frame_cnt = '0;

    case (stg_kind_r)
      wsw_rc_pkg::K_NEW_FRAME: begin
        if (!active_r && phase_r != wsw_rc_pkg::PH_SACK) begin
          if (stg_exp_r) begin
            oc_nxt = wsw_rc_pkg::OC_DROP_EXP;
          end else begin
            active_nxt   = 1'b1;
            act_bits_nxt = stg_bits_r;
            oc_nxt       = wsw_rc_pkg::OC_QUEUED;
            txc_nxt      = bianchi_r
              ? wsw_rc_pkg::TXC_W'(sr_r) + wsw_rc_pkg::TXC_W'(lr_r) + wsw_rc_pkg::TXC_W'(1)
              : wsw_rc_pkg::TXC_W'(ss_r) + wsw_rc_pkg::TXC_W'(sl_r) + wsw_rc_pkg::TXC_W'(1);
          end
        end
      end
      wsw_rc_pkg::K_TX_START: begin
        if (active_r && is_long) begin
          sr_nxt = '0;
          ss_nxt = '0;
        end
      end
      wsw_rc_pkg::K_TX_END_ACT: begin
        if (active_r) begin
          phase_nxt = wsw_rc_pkg::PH_WAIT;
          timer_nxt = 1'b1;
        end else if (phase_r == wsw_rc_pkg::PH_SACK) begin
          phase_nxt = wsw_rc_pkg::PH_NONE;
        end
      end
      wsw_rc_pkg::K_TX_END_OTH: begin
        if (phase_r == wsw_rc_pkg::PH_SACK) begin
          phase_nxt = wsw_rc_pkg::PH_NONE;
        end
      end
      wsw_rc_pkg::K_RX_START: begin
        if (phase_r == wsw_rc_pkg::PH_WAIT) begin
          phase_nxt = wsw_rc_pkg::PH_RECV;
        end
      end
      wsw_rc_pkg::K_RX_END: begin
        if (phase_r == wsw_rc_pkg::PH_RECV) begin
          phase_nxt = wsw_rc_pkg::PH_DONE;
          timer_nxt = 1'b1;
        end
      end
      wsw_rc_pkg::K_RX_ERROR: begin
        if (phase_r == wsw_rc_pkg::PH_RECV) begin
          phase_nxt = wsw_rc_pkg::PH_WAIT;
          to_fail   = !timer_r && active_r;
        end
      end
      wsw_rc_pkg::K_ACK_RX: begin
        if (active_r && phase_r == wsw_rc_pkg::PH_DONE) begin
          att_nxt = wsw_rc_pkg::ATT_W'(sr_r) + wsw_rc_pkg::ATT_W'(lr_r) + wsw_rc_pkg::ATT_W'(1);
          if (is_long) begin
            lr_nxt = '0;
            sl_nxt = '0;
          end else begin
            sr_nxt = '0;
            ss_nxt = '0;
          end
          active_nxt = 1'b0;
          phase_nxt  = wsw_rc_pkg::PH_NONE;
          timer_nxt  = 1'b0;
          oc_nxt     = wsw_rc_pkg::OC_SUCCESS;
        end
      end
      wsw_rc_pkg::K_DATA_RX: begin
        phase_nxt = wsw_rc_pkg::PH_SACK;
        oc_nxt    = wsw_rc_pkg::OC_ACK_SEND;
      end
      wsw_rc_pkg::K_ACK_TIMEOUT: begin
        timer_nxt = 1'b0;
        to_fail   = phase_r != wsw_rc_pkg::PH_RECV && active_r;
      end
      wsw_rc_pkg::K_CTS_MISSING: begin
        if (active_r) begin
          sr_nxt  = (sr_r < wsw_rc_pkg::RETRY_MAX) ? sr_r + 1'b1 : sr_r;
          ss_nxt  = (ss_r < wsw_rc_pkg::STA_MAX) ? ss_r + 1'b1 : ss_r;
          do_fail = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // timeout-type failure charges the short or long counters by frame size
    if (to_fail) begin
      if (!is_long) begin
        sr_nxt = (sr_r < wsw_rc_pkg::RETRY_MAX) ? sr_r + 1'b1 : sr_r;
        ss_nxt = (ss_r < wsw_rc_pkg::STA_MAX) ? ss_r + 1'b1 : ss_r;
      end else begin
        lr_nxt = (lr_r < wsw_rc_pkg::RETRY_MAX) ? lr_r + 1'b1 : lr_r;
        sl_nxt = (sl_r < wsw_rc_pkg::STA_MAX) ? sl_r + 1'b1 : sl_r;
      end
      do_fail = 1'b1;
    end

    // standard tx count: station counters at or past their limit wrap back by it
    s_part = (ss_nxt >= wsw_rc_pkg::STA_W'(short_lim_r))
           ? ss_nxt - wsw_rc_pkg::STA_W'(short_lim_r) : ss_nxt;
    l_part = (sl_nxt >= wsw_rc_pkg::STA_W'(long_lim_r))
           ? sl_nxt - wsw_rc_pkg::STA_W'(long_lim_r) : sl_nxt;
    if (ss_nxt < wsw_rc_pkg::STA_W'(short_lim_r) && sl_nxt < wsw_rc_pkg::STA_W'(long_lim_r)) begin
      std_cnt = wsw_rc_pkg::TXC_W'(ss_nxt) + wsw_rc_pkg::TXC_W'(sl_nxt) + wsw_rc_pkg::TXC_W'(1);
    end else begin
      std_cnt = wsw_rc_pkg::TXC_W'(s_part) + wsw_rc_pkg::TXC_W'(l_part) + wsw_rc_pkg::TXC_W'(1);
    end
    per_frame_cnt = wsw_rc_pkg::TXC_W'(sr_nxt) + wsw_rc_pkg::TXC_W'(lr_nxt)
                  + wsw_rc_pkg::TXC_W'(1);

    if (do_fail) begin
      timer_nxt = 1'b0;
      phase_nxt = wsw_rc_pkg::PH_NONE;
      if (sr_nxt == short_lim_r || lr_nxt == long_lim_r || stg_exp_r) begin
        att_nxt    = wsw_rc_pkg::ATT_W'(sr_nxt) + wsw_rc_pkg::ATT_W'(lr_nxt)
                   + wsw_rc_pkg::ATT_W'(1);
        sr_nxt     = '0;
        lr_nxt     = '0;
        active_nxt = 1'b0;
        oc_nxt     = wsw_rc_pkg::OC_DISCARD;
      end else begin
        txc_nxt = bianchi_r ? per_frame_cnt : std_cnt;
        oc_nxt  = wsw_rc_pkg::OC_RETRANSMIT;
      end
    end

    busy_nxt = active_nxt || phase_nxt == wsw_rc_pkg::PH_SACK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_lim_r <= wsw_rc_pkg::SHORT_LIMIT_RST;
      long_lim_r  <= wsw_rc_pkg::LONG_LIMIT_RST;
      thr_r       <= wsw_rc_pkg::RTS_THRESH_RST;
      bianchi_r   <= 1'b0;
      stg_v_r     <= 1'b0;
      out_v_r     <= 1'b0;
      phase_r     <= wsw_rc_pkg::PH_NONE;
      active_r    <= 1'b0;
      timer_r     <= 1'b0;
      act_bits_r  <= '0;
      sr_r        <= '0;
      lr_r        <= '0;
      ss_r        <= '0;
      sl_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          wsw_rc_pkg::REG_SHORT_LIMIT: short_lim_r <= cfg_wdata[wsw_rc_pkg::LIMIT_W-1:0];
          wsw_rc_pkg::REG_LONG_LIMIT:  long_lim_r  <= cfg_wdata[wsw_rc_pkg::LIMIT_W-1:0];
          wsw_rc_pkg::REG_RTS_THRESH:  thr_r       <= cfg_wdata[wsw_rc_pkg::BITS_W-1:0];
          wsw_rc_pkg::REG_BIANCHI:     bianchi_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        stg_v_r <= 1'b1;
      end else if (fire) begin
        stg_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r    <= 1'b1;
        phase_r    <= phase_nxt;
        active_r   <= active_nxt;
        timer_r    <= timer_nxt;
        act_bits_r <= act_bits_nxt;
        sr_r       <= sr_nxt;
        lr_r       <= lr_nxt;
        ss_r       <= ss_nxt;
        sl_r       <= sl_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_kind_r <= in_tuser;
      stg_bits_r <= in_tdata[wsw_rc_pkg::BITS_W-1:0];
      stg_exp_r  <= in_tdata[wsw_rc_pkg::BITS_W];
    end
    if (fire) begin
      oc_r     <= oc_nxt;
      txc_r    <= txc_nxt;
      att_r    <= att_nxt;
      ph_out_r <= phase_nxt;
      busy_r   <= busy_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = oc_r;
  assign out_tdata  = {1'b0, busy_r, ph_out_r, att_r, txc_r};

endmodule
